// ===== rtl/tgw_pkg.sv =====
// shared types and constants for the tilt gesture wake detector
package tgw_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = SampleW + 1;
  localparam int unsigned RatioW  = 4;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ProdW   = MagW + RatioW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WAKE_LIMIT  = 2'd0,
    CFG_SLEEP_LIMIT = 2'd1,
    CFG_RATIO_LIMIT = 2'd2
  } cfg_idx_t;

  localparam logic [CountW-1:0] WAKE_LIMIT_RST  = 8'd15;
  localparam logic [CountW-1:0] SLEEP_LIMIT_RST = 8'd25;
  localparam logic [RatioW-1:0] RATIO_LIMIT_RST = 4'd5;
  localparam logic [CountW-1:0] COUNT_TOP       = 8'hFF;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    logic                      sample_valid;
  } in_word_t;

  typedef struct packed {
    logic              display_on;
    logic [CountW-1:0] run_count;
    logic              pose_match;
    logic              wake_pulse;
    logic              sleep_pulse;
  } out_word_t;

endpackage

// ===== rtl/tgw_pose.sv =====
// tilt pose test on one sample, exact integer compares
module tgw_pose (
  input  logic signed [tgw_pkg::SampleW-1:0] x,
  input  logic signed [tgw_pkg::SampleW-1:0] y,
  input  logic signed [tgw_pkg::SampleW-1:0] z,
  input  logic [tgw_pkg::RatioW-1:0]         ratio_limit,
  output logic                               match
);

  logic [tgw_pkg::MagW-1:0]  ext_x, ext_y, ext_z;
  logic [tgw_pkg::MagW-1:0]  mag_x, mag_y, mag_z;
  logic [tgw_pkg::ProdW-1:0] y_bound;
  logic                      nonzero, same_sign, x_small, y_in_ratio;

  assign ext_x = {x[tgw_pkg::SampleW-1], x};
  assign ext_y = {y[tgw_pkg::SampleW-1], y};
  assign ext_z = {z[tgw_pkg::SampleW-1], z};

  // 17-bit magnitudes so that -32768 stays exact
  assign mag_x = x[tgw_pkg::SampleW-1] ? (~ext_x + 1'b1) : ext_x;
  assign mag_y = y[tgw_pkg::SampleW-1] ? (~ext_y + 1'b1) : ext_y;
  assign mag_z = z[tgw_pkg::SampleW-1] ? (~ext_z + 1'b1) : ext_z;

  assign y_bound = tgw_pkg::ProdW'(ratio_limit) * tgw_pkg::ProdW'(mag_z);

  assign nonzero    = (y != '0) && (z != '0);
  assign same_sign  = (y[tgw_pkg::SampleW-1] == z[tgw_pkg::SampleW-1]);
  assign x_small    = (mag_x < mag_y) && (mag_x < mag_z);
  assign y_in_ratio = (tgw_pkg::ProdW'(mag_y) < y_bound);

  assign match = nonzero && same_sign && x_small && y_in_ratio;

endmodule

// ===== rtl/tilt_gesture_wake_detector.sv =====
// tilt gesture wake detector top level: sample register, pose test, wake/sleep counter
//
// in_word carries one accelerometer sample per word; sample_valid low means the
// read failed and the last held sample is tested again. every accepted input word
// produces exactly one out_word: screen state, run counter, pose result and
// wake/sleep pulses after that sample.
// each word passes the input register, then the pose test and counter
// update into the output register. one word per cycle is sustained while out_stall
// is low; the counter and screen state feed back within that single update stage.
// when out_stall is high the output register holds its word; in_stall rises
// only while the input register is full and cannot move on.
// cfg_ready is always high; writes to an unknown index are dropped. write the
// limits only while no words are in flight.
// synchronous reset clears both stages, sets the screen on, the counter and held
// sample to zero and the limits to 15 (wake), 25 (sleep) and 5 (y/z ratio).
module tilt_gesture_wake_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tgw_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tgw_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tgw_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [tgw_pkg::CfgDatW-1:0]    cfg_data
);

  logic [tgw_pkg::CountW-1:0] wake_limit_r, sleep_limit_r;
  logic [tgw_pkg::RatioW-1:0] ratio_limit_r;

  logic                       s1_valid_r;
  tgw_pkg::in_word_t          s1_word_r;
  logic                       out_valid_r;
  tgw_pkg::out_word_t         out_word_r, out_word_nxt;

  logic signed [tgw_pkg::SampleW-1:0] held_x_r, held_y_r, held_z_r;
  logic signed [tgw_pkg::SampleW-1:0] cur_x, cur_y, cur_z;
  logic                       screen_r, screen_nxt;
  logic [tgw_pkg::CountW-1:0] count_r, count_nxt, count_bump;

  logic                       out_adv, s1_adv, in_take, match;

  assign cfg_ready = 1'b1;

  // output register frees up when empty or taken this cycle
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_limit_r  <= tgw_pkg::WAKE_LIMIT_RST;
      sleep_limit_r <= tgw_pkg::SLEEP_LIMIT_RST;
      ratio_limit_r <= tgw_pkg::RATIO_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (tgw_pkg::cfg_idx_t'(cfg_index))
        tgw_pkg::CFG_WAKE_LIMIT:  wake_limit_r  <= cfg_data;
        tgw_pkg::CFG_SLEEP_LIMIT: sleep_limit_r <= cfg_data;
        tgw_pkg::CFG_RATIO_LIMIT: ratio_limit_r <= cfg_data[tgw_pkg::RatioW-1:0];
        default: ;
      endcase
    end
  end

  // held sample is replaced only by a valid read
  assign cur_x = s1_word_r.sample_valid ? s1_word_r.accel_x : held_x_r;
  assign cur_y = s1_word_r.sample_valid ? s1_word_r.accel_y : held_y_r;
  assign cur_z = s1_word_r.sample_valid ? s1_word_r.accel_z : held_z_r;

  tgw_pose u_pose (
    .x           (cur_x),
    .y           (cur_y),
    .z           (cur_z),
    .ratio_limit (ratio_limit_r),
    .match       (match)
  );

  assign count_bump = (count_r == tgw_pkg::COUNT_TOP) ? count_r : (count_r + 1'b1);

  always_comb begin
    screen_nxt   = screen_r;
    count_nxt    = count_r;
    out_word_nxt = '0;
    out_word_nxt.pose_match = match;
    if (!screen_r) begin
      // screen off: run of matches
      count_nxt = match ? count_bump : '0;
      if (count_nxt > wake_limit_r) begin
        screen_nxt = 1'b1;
        count_nxt  = '0;
        out_word_nxt.wake_pulse = 1'b1;
      end
    end else begin
      // screen on: run of misses
      count_nxt = match ? '0 : count_bump;
      if (count_nxt > sleep_limit_r) begin
        screen_nxt = 1'b0;
        count_nxt  = '0;
        out_word_nxt.sleep_pulse = 1'b1;
      end
    end
    out_word_nxt.display_on = screen_nxt;
    out_word_nxt.run_count  = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      screen_r    <= 1'b1;
      count_r     <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_z_r    <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv) begin
        screen_r <= screen_nxt;
        count_r  <= count_nxt;
        held_x_r <= cur_x;
        held_y_r <= cur_y;
        held_z_r <= cur_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (s1_adv) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_word_r.wake_pulse && out_word_r.sleep_pulse))
    else $error("wake and sleep pulse in the same word");

  a_wake_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.wake_pulse) |->
      (out_word_r.display_on && out_word_r.pose_match && out_word_r.run_count == '0))
    else $error("wake word with screen off, miss or nonzero count");

  a_sleep_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.sleep_pulse) |->
      (!out_word_r.display_on && out_word_r.run_count == '0))
    else $error("sleep word with screen on or nonzero count");

  a_state_track: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (out_word_r.display_on == screen_r && out_word_r.run_count == count_r))
    else $error("output word out of step with counter state");
`endif

endmodule
